>>> rtl/x86eu_pkg.sv
// Package: operation codes, field widths and shared command/status types.
`timescale 1ns / 1ps
package x86eu_pkg;
  localparam int ADDR_BITS_DEFAULT = 16;
  localparam logic [15:0] SP_RESET = 16'hFFFE;

  typedef enum logic [3:0] {
    ACT_MOV = 4'd0, ACT_ADD = 4'd1, ACT_AND = 4'd2, ACT_OR = 4'd3,
    ACT_XOR = 4'd4, ACT_SUB = 4'd5, ACT_INC = 4'd6, ACT_DEC = 4'd7,
    ACT_MUL = 4'd8, ACT_DIV = 4'd9, ACT_PUSH = 4'd10, ACT_POP = 4'd11
  } action_t;

  localparam logic [1:0] SRC_REG = 2'd0;
  localparam logic [1:0] SRC_IMM = 2'd1;
  localparam logic [1:0] SRC_MEM = 2'd2;

  typedef struct packed {
    logic [3:0]  action;
    logic        is_word;
    logic        dest_is_memory;
    logic [2:0]  dest_reg;
    logic [1:0]  source_kind;
    logic [2:0]  source_reg;
    logic [15:0] immediate;
    logic [15:0] address;
  } item_t;

  typedef struct packed {
    logic [15:0] value;
    logic        borrow;
    logic        high_nonzero;
    logic        divide_error;
  } result_t;

  // Datapath command codes issued by the controller.
  typedef enum logic [3:0] {
    CMD_NONE    = 4'd0,
    CMD_LOAD    = 4'd1,  // latch item, clear memory operand
    CMD_MEMRD0  = 4'd2,  // issue read of low byte
    CMD_MEMRD1  = 4'd3,  // capture low byte, issue high byte read
    CMD_MEMRD2  = 4'd4,  // capture high byte
    CMD_EXEC    = 4'd5,  // compute result, start divide
    CMD_DIVSTEP = 4'd6,
    CMD_WRITE0  = 4'd7,  // commit registers, write low byte
    CMD_WRITE1  = 4'd8,  // write high byte
    CMD_CLEAR   = 4'd9
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
  } ctl_t;

  typedef struct packed {
    logic need_mem_read;
    logic is_div;
    logic div_done;
    logic need_wr_hi;
    logic clear_done;
  } sts_t;
endpackage

>>> rtl/x86eu_if.sv
// Valid/ready channel interface carrying one word of payload.
`timescale 1ns / 1ps
interface x86eu_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/x86eu_ctrl.sv
// Controller state machine sequencing memory access, execution and write-back.
`timescale 1ns / 1ps
module x86eu_ctrl import x86eu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output ctl_t ctl
);
  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001, S_IDLE = 10'b0000000010,
    S_RD0   = 10'b0000000100, S_RD1  = 10'b0000001000,
    S_RD2   = 10'b0000010000, S_EXEC = 10'b0000100000,
    S_DIV   = 10'b0001000000, S_WR0  = 10'b0010000000,
    S_WR1   = 10'b0100000000, S_OUT  = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    ctl.cmd = CMD_NONE;
    unique case (state)
      S_CLEAR: begin
        ctl.cmd = CMD_CLEAR;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: if (in_valid) begin
        ctl.cmd = CMD_LOAD;
        state_next = S_RD0;
      end
      S_RD0: begin
        if (sts.need_mem_read) begin
          ctl.cmd = CMD_MEMRD0;
          state_next = S_RD1;
        end else state_next = S_EXEC;
      end
      S_RD1: begin
        ctl.cmd = CMD_MEMRD1;
        state_next = S_RD2;
      end
      S_RD2: begin
        ctl.cmd = CMD_MEMRD2;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        ctl.cmd = CMD_EXEC;
        state_next = sts.is_div ? S_DIV : S_WR0;
      end
      S_DIV: begin
        ctl.cmd = CMD_DIVSTEP;
        if (sts.div_done) state_next = S_WR0;
      end
      S_WR0: begin
        ctl.cmd = CMD_WRITE0;
        state_next = sts.need_wr_hi ? S_WR1 : S_OUT;
      end
      S_WR1: begin
        ctl.cmd = CMD_WRITE1;
        state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end
endmodule

>>> rtl/x86eu_dp.sv
// Datapath: register file, byte memory, ALU, multiplier and serial divider.
`timescale 1ns / 1ps
module x86eu_dp import x86eu_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  ctl_t    ctl,
  output sts_t    sts,
  input  item_t   item_in,
  output result_t res
);
  localparam int DEPTH = 1 << ADDR_BITS;

  logic [7:0]  mem [DEPTH];
  logic [15:0] regs [8];
  item_t       it;
  logic [7:0]  rd_data;
  logic [ADDR_BITS-1:0] rd_addr, wr_addr, clr_addr;
  logic        wr_en;
  logic [7:0]  wr_data;
  logic [15:0] mem_val;
  logic [15:0] wval;         // value to commit
  logic [15:0] sp_new;
  logic        commit_dest, commit_sp, commit_mul, mem_dest;
  logic [ADDR_BITS-1:0] wbase;
  logic [15:0] dq;           // divide quotient
  logic [15:0] drem;
  logic [31:0] dnum;
  logic [4:0]  dcnt;
  logic [15:0] ddiv;
  logic        dword;
  logic [15:0] mul_hi;
  logic        wr_hi_q;
  logic        div_err;
  logic        ovf;

  action_t act;
  logic w;
  logic [15:0] mask;
  assign act  = action_t'(it.action);
  assign w    = it.is_word | act == ACT_PUSH | act == ACT_POP;
  assign mask = w ? 16'hFFFF : 16'h00FF;

  function automatic logic [15:0] rget(input logic [15:0] r [8], input logic [2:0] i,
                                       input logic wd);
    logic [15:0] x;
    x = r[{1'b0, i[1:0]}];
    if (wd) return r[i];
    return i[2] ? {8'h00, x[15:8]} : {8'h00, x[7:0]};
  endfunction

  // Map a 16-bit address onto the memory's address width.
  function automatic logic [ADDR_BITS-1:0] to_addr(input logic [15:0] a);
    logic [31:0] a32;
    a32 = {16'h0000, a};
    return a32[ADDR_BITS-1:0];
  endfunction

  logic mem_src, mem_dst_rd, stack_rd;
  assign mem_src    = it.source_kind == SRC_MEM &&
                      (act == ACT_MOV || (act >= ACT_ADD && act <= ACT_SUB) ||
                       act == ACT_MUL || act == ACT_DIV || act == ACT_PUSH);
  assign mem_dst_rd = it.dest_is_memory &&
                      ((act >= ACT_ADD && act <= ACT_SUB) || act == ACT_INC ||
                       act == ACT_DEC);
  assign stack_rd   = act == ACT_POP;

  logic [ADDR_BITS-1:0] base_addr;
  assign base_addr = stack_rd ? to_addr(regs[7]) : to_addr(it.address);

  // Operands: memory value stands for whichever operand is in memory.
  logic [15:0] src, dst;
  always_comb begin
    if (it.source_kind == SRC_REG) src = rget(regs, it.source_reg, w);
    else if (it.source_kind == SRC_MEM) src = mem_val & mask;
    else src = it.immediate & mask;
    dst = it.dest_is_memory ? (mem_val & mask) : rget(regs, it.dest_reg, w);
  end

  logic [31:0] prod;
  assign prod = {16'h0000, (w ? regs[0] : {8'h00, regs[0][7:0]})} * {16'h0000, src};

  assign sts.need_mem_read = mem_src | mem_dst_rd | stack_rd;
  assign sts.is_div        = act == ACT_DIV;
  assign sts.div_done      = dcnt == 5'd0;
  assign sts.need_wr_hi    = wr_hi_q;
  assign sts.clear_done    = &clr_addr;

  // Decode of the execute step.
  logic [15:0] wval_next, sp_new_next;
  logic [ADDR_BITS-1:0] wbase_next;
  logic borrow_next, hinz_next, commit_dest_next, commit_sp_next, commit_mul_next;
  logic mem_dest_next, wr_hi_next;

  always_comb begin
    wval_next = '0;
    sp_new_next = regs[7];
    wbase_next = to_addr(it.address);
    borrow_next = 1'b0;
    hinz_next = 1'b0;
    commit_dest_next = 1'b0;
    commit_sp_next = 1'b0;
    commit_mul_next = 1'b0;
    mem_dest_next = 1'b0;
    wr_hi_next = 1'b0;
    unique case (act)
      ACT_MOV, ACT_ADD, ACT_AND, ACT_OR, ACT_XOR, ACT_SUB, ACT_INC,
      ACT_DEC: begin
        case (act)
          ACT_MOV: wval_next = src;
          ACT_ADD: wval_next = (dst + src) & mask;
          ACT_AND: wval_next = dst & src;
          ACT_OR:  wval_next = dst | src;
          ACT_XOR: wval_next = dst ^ src;
          ACT_SUB: wval_next = (dst - src) & mask;
          ACT_INC: wval_next = (dst + 16'd1) & mask;
          default: wval_next = (dst - 16'd1) & mask;
        endcase
        borrow_next = (act == ACT_SUB && dst < src) ||
                      (act == ACT_DEC && dst == 16'd0);
        commit_dest_next = ~it.dest_is_memory;
        mem_dest_next = it.dest_is_memory;
        wr_hi_next = it.dest_is_memory & w;
      end
      ACT_MUL: begin
        wval_next = prod[15:0];
        hinz_next = w ? (prod[31:16] != 16'd0) : (prod[15:8] != 8'd0);
        commit_mul_next = 1'b1;
      end
      ACT_PUSH: begin
        wval_next = src;
        sp_new_next = regs[7] - 16'd2;
        wbase_next = to_addr(regs[7] - 16'd2);
        commit_sp_next = 1'b1;
        mem_dest_next = 1'b1;
        wr_hi_next = 1'b1;
      end
      ACT_POP: begin
        wval_next = mem_val;
        sp_new_next = regs[7] + 16'd2;
        commit_sp_next = 1'b1;
        commit_dest_next = ~it.dest_is_memory;
        mem_dest_next = it.dest_is_memory;
        wr_hi_next = it.dest_is_memory;
      end
      default: ;
    endcase
  end

  // Divide by restoring shift-subtract, one quotient bit per cycle.
  logic [17:0] trial;
  assign trial = {1'b0, drem, dnum[31]} - {2'b00, ddiv};

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (ctl.cmd == CMD_CLEAR) clr_addr <= clr_addr + ADDR_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    wr_en = 1'b0; wr_addr = wbase; wr_data = wval[7:0];
    rd_addr = base_addr;
    if (ctl.cmd == CMD_CLEAR) begin
      wr_en = 1'b1; wr_addr = clr_addr; wr_data = 8'h00;
    end else if (ctl.cmd == CMD_WRITE0) begin
      wr_en = mem_dest;
    end else if (ctl.cmd == CMD_WRITE1) begin
      wr_en = 1'b1; wr_addr = wbase + ADDR_BITS'(1); wr_data = wval[15:8];
    end
    if (ctl.cmd == CMD_MEMRD1) rd_addr = base_addr + ADDR_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 7; i++) regs[i] <= '0;
      regs[7] <= SP_RESET;
      dcnt <= '0;
    end else begin
      unique case (ctl.cmd)
        CMD_LOAD: begin
          it <= item_in;
          mem_val <= '0;
        end
        CMD_MEMRD1: mem_val[7:0] <= rd_data;
        CMD_MEMRD2: mem_val[15:8] <= rd_data;
        CMD_EXEC: begin
          res <= '{value: 16'h0000, borrow: borrow_next, high_nonzero: hinz_next,
                   divide_error: 1'b0};
          wval <= wval_next;
          mul_hi <= prod[31:16];
          sp_new <= sp_new_next;
          wbase <= wbase_next;
          commit_dest <= commit_dest_next;
          commit_sp <= commit_sp_next;
          commit_mul <= commit_mul_next;
          mem_dest <= mem_dest_next;
          wr_hi_q <= wr_hi_next;
          dword <= w;
          ddiv <= src;
          // Start from the high half; the overflow check keeps it below the divisor.
          dnum <= w ? {regs[0], 16'h0000} : {regs[0][7:0], 24'h000000};
          drem <= w ? regs[3] : {8'h00, regs[0][15:8]};
          dq <= '0;
          dcnt <= w ? 5'd16 : 5'd8;
        end
        CMD_DIVSTEP: if (dcnt != 5'd0) begin
          dnum <= {dnum[30:0], 1'b0};
          if (!trial[17]) begin
            drem <= trial[15:0];
            dq <= {dq[14:0], 1'b1};
          end else begin
            drem <= {drem[14:0], dnum[31]};
            dq <= {dq[14:0], 1'b0};
          end
          dcnt <= dcnt - 5'd1;
        end
        CMD_WRITE0: begin
          // A pop into sp keeps the popped word.
          if (commit_sp && !(commit_dest && it.dest_reg == 3'd7)) regs[7] <= sp_new;
          if (commit_dest) begin
            if (w) regs[it.dest_reg] <= wval;
            else if (it.dest_reg[2]) regs[{1'b0, it.dest_reg[1:0]}][15:8] <= wval[7:0];
            else regs[{1'b0, it.dest_reg[1:0]}][7:0] <= wval[7:0];
          end
          if (commit_mul) begin
            regs[0] <= wval;
            if (dword) regs[3] <= mul_hi;
          end
          if (act == ACT_DIV) begin
            if (div_err) res.divide_error <= 1'b1;
            else begin
              res.value <= dq;
              if (dword) begin
                regs[0] <= dq;
                regs[3] <= drem;
              end else regs[0] <= {drem[7:0], dq[7:0]};
            end
          end else res.value <= wval;
        end
        default: ;
      endcase
    end
  end

  // Overflow: divisor zero or high part of numerator not below divisor (checked before steps).
  always_ff @(posedge clk) begin
    if (ctl.cmd == CMD_EXEC)
      ovf <= (src == 16'd0) ||
             (w ? (regs[3] >= src) : ({8'h00, regs[0][15:8]} >= src));
  end
  assign div_err = ovf;
endmodule

>>> rtl/x86_16bit_execute_unit.sv
// Top level of the 16-bit execute unit.
`timescale 1ns / 1ps
// Usage:
//   Input channel "op" carries one decoded operation per word; output channel
//   "res" returns exactly one result word per operation, in order.
//   An operation is taken only when the unit is idle; the unit then decodes
//   it, reads a memory operand or the stack when one is needed, executes,
//   steps the divider for a divide, writes back (a memory result low byte
//   first, then the high byte for a word), then presents the result. A new
//   operation is taken only after the last result has been accepted.
//   The byte memory has one write and one read port, so a memory word is
//   read or written as two bytes in turn.
//   After reset the unit clears the whole memory, one byte per cycle, with
//   ready low; registers are zero, sp 0xFFFE.
//   When the receiver stalls, the result is held and no new word is taken.
module x86_16bit_execute_unit import x86eu_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input logic clk,
  input logic rst,
  x86eu_if.sink   op,
  x86eu_if.source res
);
  ctl_t ctl;
  sts_t sts;
  result_t r;

  x86eu_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(op.valid), .in_ready(op.ready),
    .out_valid(res.valid), .out_ready(res.ready),
    .sts(sts), .ctl(ctl)
  );

  x86eu_dp #(.ADDR_BITS(ADDR_BITS)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .item_in(op.data), .res(r)
  );

  assign res.data = r;
endmodule
